// File: hw/rtl/ulasm_pkg.sv
// Shared constants for the receive line assembler: result kinds, line-ending
// characters, field widths and the default ring depth. No dependencies.
package ulasm_pkg;

	localparam int ULASM_DEPTH = 32;
	localparam int POS_W       = 5;

	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_CHAR = 2'd1;
	localparam logic [1:0] KIND_TERM = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_NUL = 8'h00;

endpackage

// File: hw/rtl/ulasm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module ulasm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/uart_rx_line_assembler_core.sv
// Top level of the receive line assembler: receive ring, poll sequencer and
// result register. Depends on ulasm_pkg and ulasm_ram.
//
// Usage: an item is accepted at a rising edge with start high and busy low.
// With action low, rx_byte is pushed into the ring; one push acknowledge
// appears on the result ports in the next cycle, marked by strobe, and busy
// stays low, so a push can be accepted in every cycle.
// With action high, the poll drains the ring one entry per cycle through the
// RAM read port. Each line character or terminator write is one strobed
// result, and a poll-done result with last set closes the poll. Busy stays
// high while the ring is read, while the last read passes the registered
// RAM output, and until the done result is issued. A poll of an empty ring
// keeps busy high for one cycle.
// Each result is on the ports for exactly one cycle; the receiver cannot
// stall the block, so no result is ever held back.
// Reset empties the ring, clears the line position and the sticky overflow
// flag, and leaves the ring contents undefined; no clearing pass is needed.
module uart_rx_line_assembler_core
	import ulasm_pkg::*;
#(
	parameter int DEPTH = ULASM_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             action,
	input  logic [7:0]       rx_byte,
	output logic             busy,
	output logic             strobe,
	output logic [1:0]       kind,
	output logic [POS_W-1:0] position,
	output logic [7:0]       char_value,
	output logic             line_complete,
	output logic             byte_dropped,
	output logic             overflow_seen,
	output logic             last
);

	localparam int AW = $clog2(DEPTH);
	localparam int PW = (AW > POS_W) ? AW : POS_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	logic          state_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW-1:0] line_pos_q;
	logic          overflow_q;
	logic          complete_q;
	logic          valid_s1;
	logic [7:0]    rd_data_s1;

	logic          strobe_q;
	logic [1:0]    kind_q;
	logic [POS_W-1:0] position_q;
	logic [7:0]    char_q;
	logic          line_complete_q;
	logic          dropped_q;
	logic          last_q;

	logic          push_acc;
	logic          poll_acc;
	logic          full;
	logic          ram_we;
	logic          rd_en;
	logic          is_eol;
	logic          emit_term;
	logic          emit_char;
	logic          done_now;
	logic [PW-1:0] pos_wide;

	assign busy     = (state_q == ST_WALK);
	assign push_acc = start && !busy && !action;
	assign poll_acc = start && !busy && action;
	assign full     = (next_idx(head_q) == tail_q);
	assign ram_we   = push_acc && !full;
	assign rd_en    = (state_q == ST_WALK) && (tail_q != head_q);
	assign done_now = (state_q == ST_WALK) && (tail_q == head_q) && !valid_s1;

	assign is_eol    = (rd_data_s1 == CH_CR) || (rd_data_s1 == CH_LF);
	assign emit_term = is_eol && (line_pos_q != '0);
	assign emit_char = !is_eol && (line_pos_q != AW'(DEPTH - 1));
	assign pos_wide  = PW'(line_pos_q);

	ulasm_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_q),
		.wdata (rx_byte),
		.re    (rd_en),
		.raddr (tail_q),
		.rdata (rd_data_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			line_pos_q <= '0;
			overflow_q <= 1'b0;
			complete_q <= 1'b0;
			valid_s1   <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			strobe_q <= push_acc || (valid_s1 && (emit_term || emit_char)) || done_now;
			if (push_acc) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					head_q <= next_idx(head_q);
				end
			end
			if (poll_acc) begin
				state_q    <= ST_WALK;
				complete_q <= 1'b0;
			end
			if (rd_en) begin
				tail_q <= next_idx(tail_q);
			end
			if (valid_s1) begin
				if (emit_term) begin
					line_pos_q <= '0;
					complete_q <= 1'b1;
				end else if (emit_char) begin
					line_pos_q <= line_pos_q + 1'b1;
				end
			end
			if (done_now) begin
				state_q <= ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (push_acc) begin
			kind_q          <= KIND_PUSH;
			position_q      <= '0;
			char_q          <= CH_NUL;
			line_complete_q <= 1'b0;
			dropped_q       <= full;
			last_q          <= 1'b1;
		end else if (valid_s1) begin
			kind_q          <= emit_term ? KIND_TERM : KIND_CHAR;
			position_q      <= pos_wide[POS_W-1:0];
			char_q          <= emit_term ? CH_NUL : rd_data_s1;
			line_complete_q <= 1'b0;
			dropped_q       <= 1'b0;
			last_q          <= 1'b0;
		end else begin
			kind_q          <= KIND_DONE;
			position_q      <= '0;
			char_q          <= CH_NUL;
			line_complete_q <= complete_q;
			dropped_q       <= 1'b0;
			last_q          <= 1'b1;
		end
	end

	assign strobe        = strobe_q;
	assign kind          = kind_q;
	assign position      = position_q;
	assign char_value    = char_q;
	assign line_complete = line_complete_q;
	assign byte_dropped  = dropped_q;
	assign overflow_seen = overflow_q;
	assign last          = last_q;

endmodule

// File: bench/uart_rx_line_assembler_core_tb.sv
// Self-checking testbench for uart_rx_line_assembler_core: pushes received bytes, polls the
// ring, predicts every push acknowledge, line write and poll result, and checks them
// as they are strobed out. Depends on ulasm_pkg and on the RTL of the block.
module uart_rx_line_assembler_core_tb
	import ulasm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH = ULASM_DEPTH;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POLL = 1'b1;

	typedef struct packed {
		logic [1:0]       kind;
		logic [POS_W-1:0] position;
		logic [7:0]       char_value;
		logic             line_complete;
		logic             byte_dropped;
		logic             overflow_seen;
		logic             last;
	} line_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             action = ACT_PUSH;
	logic [7:0]       rx_byte = 8'h00;
	logic             busy;
	logic             strobe;
	logic [1:0]       kind;
	logic [POS_W-1:0] position;
	logic [7:0]       char_value;
	logic             line_complete;
	logic             byte_dropped;
	logic             overflow_seen;
	logic             last;

	line_result_t pending_results[$];
	logic [7:0]   rx_ring[RING_DEPTH];
	int           ring_head = 0;
	int           ring_tail = 0;
	int           line_pos = 0;
	logic         overflow_flag = 1'b0;

	bit idle_on = 1'b1;
	int error_count = 0;
	int cycle_count = 0;
	int n_requests = 0;
	int n_pushes = 0;
	int n_polls = 0;
	int n_checked = 0;
	int n_lines = 0;
	int n_ring_drops = 0;
	int n_line_drops = 0;

	uart_rx_line_assembler_core #(
		.DEPTH(RING_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.action(action),
		.rx_byte(rx_byte),
		.busy(busy),
		.strobe(strobe),
		.kind(kind),
		.position(position),
		.char_value(char_value),
		.line_complete(line_complete),
		.byte_dropped(byte_dropped),
		.overflow_seen(overflow_seen),
		.last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		line_result_t want;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$error("Result with nothing expected: kind %0d position %0d char %0d",
					kind, position, char_value);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("kind", want.kind, kind);
				compare_field("position", want.position, position);
				compare_field("char_value", want.char_value, char_value);
				compare_field("line_complete", want.line_complete, line_complete);
				compare_field("byte_dropped", want.byte_dropped, byte_dropped);
				compare_field("overflow_seen", want.overflow_seen, overflow_seen);
				compare_field("last", want.last, last);
				n_checked++;
			end
		end
	end

	task automatic predict_request(input logic act, input logic [7:0] b);
		line_result_t r;
		logic [7:0]   c;
		logic         ended;
		if (act == ACT_PUSH) begin
			r = '0;
			r.kind = KIND_PUSH;
			r.last = 1'b1;
			if ((ring_head + 1) % RING_DEPTH != ring_tail) begin
				rx_ring[ring_head] = b;
				ring_head = (ring_head + 1) % RING_DEPTH;
			end else begin
				r.byte_dropped = 1'b1;
				overflow_flag = 1'b1;
				n_ring_drops++;
			end
			r.overflow_seen = overflow_flag;
			pending_results.push_back(r);
			n_pushes++;
		end else begin
			ended = 1'b0;
			while (ring_head != ring_tail) begin
				c = rx_ring[ring_tail];
				r = '0;
				r.overflow_seen = overflow_flag;
				if (c == CH_CR || c == CH_LF) begin
					if (line_pos != 0) begin
						r.kind = KIND_TERM;
						r.position = POS_W'(line_pos);
						r.char_value = CH_NUL;
						pending_results.push_back(r);
						line_pos = 0;
						ended = 1'b1;
						n_lines++;
					end
				end else if (line_pos < RING_DEPTH - 1) begin
					r.kind = KIND_CHAR;
					r.position = POS_W'(line_pos);
					r.char_value = c;
					pending_results.push_back(r);
					line_pos++;
				end else begin
					n_line_drops++;
				end
				ring_tail = (ring_tail + 1) % RING_DEPTH;
			end
			r = '0;
			r.kind = KIND_DONE;
			r.line_complete = ended;
			r.overflow_seen = overflow_flag;
			r.last = 1'b1;
			pending_results.push_back(r);
			n_polls++;
		end
	endtask

	task automatic send_request(input logic act, input logic [7:0] b);
		start <= 1'b1;
		action <= act;
		rx_byte <= b;
		do @(posedge clk); while (busy);
		predict_request(act, b);
		n_requests++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_line_endings();
		send_request(ACT_PUSH, 8'h00);
		send_request(ACT_PUSH, 8'hFF);
		send_request(ACT_PUSH, CH_CR);
		send_request(ACT_PUSH, CH_LF);
		send_request(ACT_POLL, 8'hFF);
		send_request(ACT_POLL, 8'h00);
		send_request(ACT_PUSH, CH_LF);
		send_request(ACT_POLL, 8'h5A);
		send_request(ACT_PUSH, "A");
		send_request(ACT_PUSH, "B");
		send_request(ACT_PUSH, CH_CR);
		send_request(ACT_PUSH, CH_LF);
		send_request(ACT_POLL, 8'hA5);
		send_request(ACT_PUSH, 8'h7F);
		send_request(ACT_PUSH, 8'h80);
		send_request(ACT_POLL, 8'h00);
		send_request(ACT_PUSH, CH_LF);
		send_request(ACT_POLL, 8'h00);
	endtask

	// The ring keeps one slot free, so the last two of these bytes are dropped.
	task automatic test_ring_overflow();
		int i;
		wait_drained();
		send_request(ACT_POLL, 8'h00);
		for (i = 0; i < RING_DEPTH + 1; i++)
			send_request(ACT_PUSH, 8'("a" + i % 26));
		send_request(ACT_POLL, 8'h00);
	endtask

	task automatic test_line_truncation();
		int i;
		for (i = 0; i < 4; i++)
			send_request(ACT_PUSH, 8'($urandom_range(8'h20, 8'h7E)));
		send_request(ACT_POLL, 8'h00);
		send_request(ACT_PUSH, CH_CR);
		send_request(ACT_POLL, 8'h00);
	endtask

	task automatic test_random_lines(input int count, input bit allow_overflow);
		int         target;
		int         len;
		int         i;
		logic [7:0] b;
		target = n_requests + count;
		while (n_requests < target) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(28, 40);
			else
				len = $urandom_range(0, 12);
			for (i = 0; i < len; i++) begin
				if ($urandom_range(0, 3) == 0)
					b = 8'($urandom_range(0, 255));
				else
					b = 8'($urandom_range(8'h20, 8'h7E));
				send_request(ACT_PUSH, b);
				if ((!allow_overflow &&
				     (ring_head - ring_tail + RING_DEPTH) % RING_DEPTH >= RING_DEPTH - 2) ||
				    $urandom_range(0, 5) == 0)
					send_request(ACT_POLL, 8'($urandom_range(0, 255)));
			end
			case ($urandom_range(0, 4))
				0: send_request(ACT_PUSH, CH_CR);
				1: send_request(ACT_PUSH, CH_LF);
				2: begin
					send_request(ACT_PUSH, CH_CR);
					send_request(ACT_PUSH, CH_LF);
				end
				3: ;
				default: begin
					send_request(ACT_PUSH, CH_LF);
					send_request(ACT_PUSH, CH_LF);
				end
			endcase
			if ($urandom_range(0, 2) != 0)
				send_request(ACT_POLL, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_line_endings();
		test_random_lines(200, 1'b0);
		test_ring_overflow();
		test_line_truncation();
		test_random_lines(140, 1'b1);
		idle_on = 1'b0;
		test_random_lines(40, 1'b1);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			error_count++;
		end
		$display("Sent %0d requests (%0d pushes, %0d polls); %0d results checked.",
			n_requests, n_pushes, n_polls, n_checked);
		$display("Lines ended: %0d; bytes dropped at a full ring: %0d, past line end: %0d.",
			n_lines, n_ring_drops, n_line_drops);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/ulasm_pkg.sv
hw/rtl/ulasm_ram.sv
hw/rtl/uart_rx_line_assembler_core.sv
bench/uart_rx_line_assembler_core_tb.sv
